// ----- rtl/assert_macros.svh -----
// assertion helpers for the rtl converter module
// all checks are clocked on i_clk and held off while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PFR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pfr_pkg.sv -----
// ---------------------------------------------------------------------------
// pfr_pkg
// types, register codes and the 5-bit to 8-bit colour scaling table
// ---------------------------------------------------------------------------
`default_nettype none

package pfr_pkg;

    localparam int unsigned C_DIM_W   = 16;
    localparam int unsigned C_COUNT_W = 2 * C_DIM_W;
    localparam int unsigned C_IDX_W   = 2;

    // register indexes on the configuration channel
    localparam logic [C_IDX_W-1:0] C_REG_PIXEL_FORMAT = 2'd0;
    localparam logic [C_IDX_W-1:0] C_REG_FRAME_WIDTH  = 2'd1;
    localparam logic [C_IDX_W-1:0] C_REG_FRAME_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        FMT_GREY8    = 2'd0,
        FMT_RGB555   = 2'd1,
        FMT_RGB888   = 2'd2,
        FMT_BGRA8888 = 2'd3
    } t_format;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       end_of_frame;
        logic       status;
    } t_out_item;

    typedef struct packed {
        logic [C_IDX_W-1:0] index;
        logic [C_DIM_W-1:0] value;
    } t_cfg_write;

    // floor(v * 255 / 31), entry 31 first
    localparam logic [31:0][7:0] C_SCALE5 = {
        8'd255, 8'd246, 8'd238, 8'd230, 8'd222, 8'd213, 8'd205, 8'd197,
        8'd189, 8'd180, 8'd172, 8'd164, 8'd156, 8'd148, 8'd139, 8'd131,
        8'd123, 8'd115, 8'd106, 8'd98,  8'd90,  8'd82,  8'd74,  8'd65,
        8'd57,  8'd49,  8'd41,  8'd32,  8'd24,  8'd16,  8'd8,   8'd0
    };

    function automatic logic [7:0] scale5(input logic [4:0] v);
        return C_SCALE5[v];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pfr_stream_if.sv -----
// ---------------------------------------------------------------------------
// pfr_stream_if
// valid/ready channel carrying one item of type T per handshake
// ---------------------------------------------------------------------------
`default_nettype none

interface pfr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/pixel_format_to_rgba.sv -----
// a result is registered and valid in the cycle after the byte that completes it is accepted
// throughput: one byte per clock, results drain from a single output register
// the input stalls only while that register is full and not being taken, while a
// configuration write is offered, and in the cycle after it while the total re-registers
// reset (synchronous, active low) sets grey8, a 1x1 frame and an empty output
// ---------------------------------------------------------------------------
// pixel_format_to_rgba
// converts a packed byte stream (grey8, rgb555, rgb888, bgra8888) to rgba
// pixels, counts pixels per frame and flags a source that ends early
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pixel_format_to_rgba (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pfr_stream_if.sink  i_cfg,
    pfr_stream_if.sink  i_in,
    pfr_stream_if.source o_out
);
    import pfr_pkg::*;

    // configuration
    t_format              r_format;
    logic [C_DIM_W-1:0]   r_width;
    logic [C_DIM_W-1:0]   r_height;
    logic [C_COUNT_W-1:0] r_total;
    logic                 r_total_zero;
    logic                 r_cfg_settle;

    // frame state
    logic [2:0][7:0]      r_hold;
    logic [1:0]           r_pos;
    logic [C_COUNT_W-1:0] r_count;
    logic                 r_frame_done;

    // output register
    logic                 r_out_valid;
    t_out_item            r_out;

    logic                 cfg_acc;
    logic                 in_acc;
    logic                 active;
    logic                 px_done;
    logic [C_COUNT_W-1:0] n_count;
    logic                 n_frame_end;
    t_out_item            n_out;
    logic                 n_emit;
    logic [15:0]          rgb555;
    logic [7:0]           data;
    logic                 last;

    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid & i_cfg.ready;

    // a configuration write takes priority over a waiting byte
    assign i_in.ready  = !r_cfg_settle && !i_cfg.valid && (!r_out_valid || o_out.ready);
    assign in_acc      = i_in.valid & i_in.ready;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign data   = i_in.data.data_byte;
    assign last   = i_in.data.last_byte;
    assign active = !r_frame_done && !r_total_zero;
    // the byte completes a pixel once the bytes held reach the format's count
    assign px_done = (r_pos >= r_format);
    assign n_count = r_count + C_COUNT_W'(1);
    assign n_frame_end = (n_count == r_total);
    assign rgb555 = {data, r_hold[0]};

    always_comb begin
        n_out = '0;
        n_out.alpha = 8'd255;
        case (r_format)
            FMT_GREY8: begin
                n_out.red   = data;
                n_out.green = data;
                n_out.blue  = data;
            end
            FMT_RGB555: begin
                n_out.red   = scale5(rgb555[14:10]);
                n_out.green = scale5(rgb555[9:5]);
                n_out.blue  = scale5(rgb555[4:0]);
            end
            FMT_RGB888: begin
                n_out.red   = r_hold[0];
                n_out.green = r_hold[1];
                n_out.blue  = data;
            end
            FMT_BGRA8888: begin
                n_out.blue  = r_hold[0];
                n_out.green = r_hold[1];
                n_out.red   = r_hold[2];
                n_out.alpha = data;
            end
            default: begin
                n_out.red   = data;
            end
        endcase
        if (px_done) begin
            n_out.end_of_frame = n_frame_end || last;
            n_out.status       = !n_frame_end && last;
        end else begin
            // short input on a partial pixel
            n_out = '0;
            n_out.end_of_frame = 1'b1;
            n_out.status       = 1'b1;
        end
        n_emit = active && (px_done || last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format     <= FMT_GREY8;
            r_width      <= C_DIM_W'(1);
            r_height     <= C_DIM_W'(1);
            r_total      <= C_COUNT_W'(1);
            r_total_zero <= 1'b0;
            r_cfg_settle <= 1'b0;
            r_pos        <= '0;
            r_count      <= '0;
            r_frame_done <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_total      <= C_COUNT_W'(r_width) * C_COUNT_W'(r_height);
            r_total_zero <= (r_width == '0) || (r_height == '0);
            r_cfg_settle <= cfg_acc;

            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (cfg_acc) begin
                case (i_cfg.data.index)
                    C_REG_PIXEL_FORMAT: begin
                        r_format <= t_format'(i_cfg.data.value[1:0]);
                    end
                    C_REG_FRAME_WIDTH: begin
                        r_width <= i_cfg.data.value;
                    end
                    C_REG_FRAME_HEIGHT: begin
                        r_height <= i_cfg.data.value;
                    end
                    default: begin
                    end
                endcase
                if (i_cfg.data.index <= C_REG_FRAME_HEIGHT) begin
                    r_pos        <= '0;
                    r_count      <= '0;
                    r_frame_done <= 1'b0;
                end
            end else if (in_acc) begin
                if (n_emit) begin
                    r_out_valid <= 1'b1;
                    r_out       <= n_out;
                end
                if (active) begin
                    if (px_done) begin
                        r_pos   <= '0;
                        r_count <= n_count;
                        if (n_frame_end) begin
                            r_frame_done <= 1'b1;
                        end
                    end else begin
                        r_pos <= r_pos + 2'd1;
                        case (r_pos)
                            2'd0: r_hold[0] <= data;
                            2'd1: r_hold[1] <= data;
                            2'd2: r_hold[2] <= data;
                            default: begin
                            end
                        endcase
                    end
                end
                // end of buffer starts a new frame
                if (last) begin
                    r_pos        <= '0;
                    r_count      <= '0;
                    r_frame_done <= 1'b0;
                end
            end
        end
    end

    `PFR_ASSERT_NEXT(a_cfg_settles, cfg_acc, !in_acc, "byte taken while total re-registers")
    `PFR_ASSERT_IMPL(a_status_eof, r_out_valid && r_out.status, r_out.end_of_frame,
                     "short-input status without end of frame")
    `PFR_ASSERT_IMPL(a_pos_in_range, 1'b1, r_pos <= r_format, "byte position beyond pixel size")
    `PFR_ASSERT_NEXT(a_last_restarts, in_acc && last, r_pos == '0 && r_count == '0,
                     "end of buffer did not restart the frame")

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// byte stream to rgba converter: directed and random frames in every source
// format, with random idling on both sides, checked against an inline model
// ---------------------------------------------------------------------------

module tb;
    import pfr_pkg::*;

    localparam int unsigned RAND_ITEMS  = 1250;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam logic [C_IDX_W-1:0] C_REG_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;

    pfr_stream_if #(.T(t_cfg_write)) cfg_if ();
    pfr_stream_if #(.T(t_in_item))   byte_if ();
    pfr_stream_if #(.T(t_out_item))  pixel_if ();

    pixel_format_to_rgba dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (byte_if),
        .o_out   (pixel_if)
    );

    // model configuration and frame state
    t_format     cur_fmt;
    logic [15:0] cur_width;
    logic [15:0] cur_height;
    logic [23:0] asm_bytes;
    logic [1:0]  asm_count;
    logic [31:0] px_in_frame;
    logic        frame_closed;

    t_in_item    byte_queue[$];
    t_out_item   pixels_due[$];
    t_out_item   pixel_want;
    t_out_item   pixel_got;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned bytes_taken;
    int unsigned hold_left;
    logic        hold_done;
    int unsigned cycles;
    int unsigned errors;
    int unsigned counted;

    always #1 i_clk = ~i_clk;

    function automatic logic [7:0] five_to_eight(input logic [4:0] v);
        return 8'((int'(v) * 255) / 31);
    endfunction

    task automatic clear_frame();
        asm_bytes    = '0;
        asm_count    = '0;
        px_in_frame  = '0;
        frame_closed = 1'b0;
    endtask

    // expected pixel, if any, for one accepted byte
    task automatic convert_byte(input t_in_item it);
        logic [31:0] total;
        logic [2:0]  bpp;
        logic [15:0] p555;
        t_out_item   px;
        total = 32'(cur_width) * 32'(cur_height);
        bpp   = {1'b0, cur_fmt} + 3'd1;
        px    = '0;
        if (total == 0 || px_in_frame >= total) begin
            frame_closed = 1'b1;
        end
        if (!frame_closed) begin
            if ({1'b0, asm_count} + 3'd1 >= bpp) begin
                px.alpha = 8'hFF;
                case (cur_fmt)
                    FMT_GREY8: begin
                        px.red   = it.data_byte;
                        px.green = it.data_byte;
                        px.blue  = it.data_byte;
                    end
                    FMT_RGB555: begin
                        p555     = {it.data_byte, asm_bytes[7:0]};
                        px.red   = five_to_eight(p555[14:10]);
                        px.green = five_to_eight(p555[9:5]);
                        px.blue  = five_to_eight(p555[4:0]);
                    end
                    FMT_RGB888: begin
                        px.red   = asm_bytes[7:0];
                        px.green = asm_bytes[15:8];
                        px.blue  = it.data_byte;
                    end
                    default: begin
                        px.blue  = asm_bytes[7:0];
                        px.green = asm_bytes[15:8];
                        px.red   = asm_bytes[23:16];
                        px.alpha = it.data_byte;
                    end
                endcase
                asm_bytes   = '0;
                asm_count   = '0;
                px_in_frame = px_in_frame + 1;
                if (px_in_frame >= total) begin
                    frame_closed    = 1'b1;
                    px.end_of_frame = 1'b1;
                end else if (it.last_byte) begin
                    px.end_of_frame = 1'b1;
                    px.status       = 1'b1;
                end
                pixels_due.push_back(px);
            end else begin
                asm_bytes = asm_bytes | (24'(it.data_byte) << (8 * asm_count));
                asm_count = asm_count + 2'd1;
                if (it.last_byte) begin
                    px.end_of_frame = 1'b1;
                    px.status       = 1'b1;
                    pixels_due.push_back(px);
                end
            end
        end
        if (it.last_byte) begin
            clear_frame();
        end
    endtask

    task automatic write_reg(input logic [C_IDX_W-1:0] idx, input logic [15:0] val);
        t_cfg_write wr;
        wr.index = idx;
        wr.value = val;
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= wr;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            C_REG_PIXEL_FORMAT: begin
                cur_fmt = t_format'(val[1:0]);
                clear_frame();
            end
            C_REG_FRAME_WIDTH: begin
                cur_width = val;
                clear_frame();
            end
            C_REG_FRAME_HEIGHT: begin
                cur_height = val;
                clear_frame();
            end
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic push_byte(input logic [7:0] d, input logic l);
        t_in_item it;
        it.data_byte = d;
        it.last_byte = l;
        byte_queue.push_back(it);
    endtask

    // let the block drain, then let it idle past its output register
    task automatic wait_idle();
        do @(negedge i_clk);
        while (byte_queue.size() != 0 || byte_if.valid || pixels_due.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // one source buffer: complete, cut short, or noise with stray last flags
    task automatic queue_frame();
        logic [31:0] total;
        int unsigned full_len;
        int unsigned lim;
        int unsigned n;
        int unsigned kind;
        total    = 32'(cur_width) * 32'(cur_height);
        full_len = (total <= 64) ? (int'(cur_fmt) + 1) * int'(total) : 0;
        kind     = $urandom_range(99);
        if (kind >= 80) begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++) begin
                push_byte(8'($urandom), $urandom_range(5) == 0);
            end
            counted += n;
        end else if (total != 0 && total <= 64 && kind < 55) begin
            n = $urandom_range(3);
            for (int i = 0; i < full_len + n; i++) begin
                push_byte(8'($urandom), i == full_len + n - 1);
            end
            counted += full_len;
        end else begin
            lim = 40;
            if (total != 0 && total <= 64 && full_len - 1 < lim) begin
                lim = full_len - 1;
            end
            if (lim < 1) begin
                lim = 1;
            end
            n = $urandom_range(1, lim);
            for (int i = 0; i < n; i++) begin
                push_byte(8'($urandom), i == n - 1);
            end
            if (total != 0) begin
                counted += n;
            end
        end
    endtask

    task automatic cmp_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            errors++;
        end
    endtask

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_if.valid <= 1'b0;
        end else begin
            if (byte_if.valid && byte_if.ready) begin
                convert_byte(byte_if.data);
                bytes_taken <= bytes_taken + 1;
            end
            if (!byte_if.valid || byte_if.ready) begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    byte_if.valid <= 1'b1;
                    byte_if.data  <= byte_queue.pop_front();
                end else begin
                    byte_if.valid <= 1'b0;
                end
            end
        end
    end

    // pixel monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pixel_if.ready <= 1'b0;
        end else begin
            if (pixel_if.valid && pixel_if.ready) begin
                pixel_got = pixel_if.data;
                if (pixels_due.size() == 0) begin
                    $error("pixel with none due: %p", pixel_got);
                    errors++;
                end else begin
                    pixel_want = pixels_due.pop_front();
                    cmp_field("red", pixel_want.red, pixel_got.red);
                    cmp_field("green", pixel_want.green, pixel_got.green);
                    cmp_field("blue", pixel_want.blue, pixel_got.blue);
                    cmp_field("alpha", pixel_want.alpha, pixel_got.alpha);
                    cmp_field("end_of_frame", pixel_want.end_of_frame,
                              pixel_got.end_of_frame);
                    cmp_field("status", pixel_want.status, pixel_got.status);
                end
            end
            pixel_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // one long hold-off on the output while bytes are still queued
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && bytes_taken >= 40 && byte_queue.size() > 40) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [15:0] w;
        logic [15:0] h;
        logic [1:0]  fmt;
        int unsigned r;
        bit          first;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.data    = '0;
        byte_if.valid  = 1'b0;
        byte_if.data   = '0;
        pixel_if.ready = 1'b0;
        send_idle_pct  = 30;
        recv_stall_pct = 64;
        bytes_taken    = 0;
        cycles         = 0;
        errors         = 0;
        counted        = 0;
        cur_fmt        = FMT_GREY8;
        cur_width      = 16'd1;
        cur_height     = 16'd1;
        clear_frame();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: one grey pixel, then a stray byte that ends the buffer
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        wait_idle();

        // rgb555 2x2: black, white with bit 15 set, pure blue, yellow, then spare bytes
        write_reg(C_REG_PIXEL_FORMAT, 16'h0001);
        write_reg(C_REG_FRAME_WIDTH, 16'd2);
        write_reg(C_REG_FRAME_HEIGHT, 16'd2);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h1F, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hE0, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'hAA, 1'b1);
        wait_idle();

        // rgb888 in the largest frame: short input with a pixel, then without one
        write_reg(C_REG_PIXEL_FORMAT, 16'hFFFE);
        write_reg(C_REG_FRAME_WIDTH, 16'hFFFF);
        write_reg(C_REG_FRAME_HEIGHT, 16'hFFFF);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b0);
        push_byte(8'h56, 1'b1);
        push_byte(8'h9A, 1'b1);
        wait_idle();

        // bgra 1x2 with alpha at both ends
        write_reg(C_REG_PIXEL_FORMAT, 16'h0003);
        write_reg(C_REG_FRAME_WIDTH, 16'd1);
        write_reg(C_REG_FRAME_HEIGHT, 16'd2);
        push_byte(8'h10, 1'b0);
        push_byte(8'h20, 1'b0);
        push_byte(8'h30, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h40, 1'b0);
        push_byte(8'h50, 1'b0);
        push_byte(8'h60, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h77, 1'b1);
        wait_idle();

        // empty frame: nothing comes out; the unused index changes nothing
        write_reg(C_REG_FRAME_WIDTH, 16'd0);
        write_reg(C_REG_FRAME_HEIGHT, 16'd0);
        write_reg(C_REG_UNUSED, 16'h1234);
        push_byte(8'h5A, 1'b0);
        push_byte(8'hA5, 1'b1);

        first = 1'b1;
        while (counted < RAND_ITEMS) begin
            if (counted >= 2 * RAND_ITEMS / 3) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end else if (counted >= RAND_ITEMS / 3) begin
                send_idle_pct  = 64;
                recv_stall_pct = 30;
            end
            wait_idle();
            fmt = 2'($urandom);
            r   = $urandom_range(99);
            if (first) begin
                w = 16'd8;
                h = 16'd8;
            end else if (r < 6) begin
                w = 16'($urandom_range(1, 8));
                h = 16'd0;
                if ($urandom_range(1) == 1) begin
                    {w, h} = {h, w};
                end
            end else if (r < 14) begin
                w = ($urandom_range(1) == 1) ? 16'hFFFF : 16'($urandom_range(1, 16'hFFFF));
                h = 16'($urandom_range(1, 16'hFFFF));
            end else begin
                w = 16'($urandom_range(1, 8));
                h = 16'($urandom_range(1, 8));
            end
            if (fmt != cur_fmt || $urandom_range(1) == 1) begin
                write_reg(C_REG_PIXEL_FORMAT, {14'($urandom), fmt});
            end
            if (w != cur_width || $urandom_range(1) == 1) begin
                write_reg(C_REG_FRAME_WIDTH, w);
            end
            if (h != cur_height || $urandom_range(1) == 1) begin
                write_reg(C_REG_FRAME_HEIGHT, h);
            end
            if ($urandom_range(9) == 0) begin
                write_reg(C_REG_UNUSED, 16'($urandom));
            end
            if (first) begin
                // enough queued bytes for the output hold-off to back up the input
                for (int i = 0; i < 3 * 64 * (int'(cur_fmt) + 1); i++) begin
                    push_byte(8'($urandom), 1'b0);
                end
                push_byte(8'($urandom), 1'b1);
                counted += 3 * 64 * (int'(cur_fmt) + 1);
                first = 1'b0;
            end else begin
                repeat ($urandom_range(2, 5)) queue_frame();
            end
        end

        wait_idle();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/pfr_pkg.sv
rtl/pfr_stream_if.sv
rtl/pixel_format_to_rgba.sv
test/tb.sv
